[rtl/core/edge_pixel_coverage_blend_assert.svh]
// Assertion macros shared by the edge pixel coverage blend checkers.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef EDGE_PIXEL_COVERAGE_BLEND_ASSERT_SVH
`define EDGE_PIXEL_COVERAGE_BLEND_ASSERT_SVH

// expr must never be true outside reset
`define EPCB_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

// ante implies cons in the same cycle
`define EPCB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons after the ##n delay
`define EPCB_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

[rtl/core/epcb_pkg.sv]
// Package for the edge pixel coverage blend: widths, constants, case codes
// and the sideband structs carried through the divider pipelines. No dependencies.
`default_nettype none

package epcb_pkg;

    localparam int COLOR_W     = 16;
    localparam int GRAD_W      = 16;
    localparam int SLOPE_Q_W   = 16;   // slope quotient bits, Q4.12
    localparam int SLOPE_DIV_W = 16;   // |grad_y| up to 32768
    localparam int TRI_Q_W     = 17;   // triangle area quotient bits
    localparam int TRI_DIV_W   = 17;   // 2*m
    localparam int AREA_W      = 17;   // Q1.16, so 1.0 is representable

    localparam int SLOPE_BPS_DEF = 4;
    localparam int TRI_BPS_DEF   = 6;

    localparam logic [SLOPE_Q_W-1:0] SLOPE_MAX = 16'hFFFF;
    localparam logic [AREA_W-1:0]    ONE_Q16   = 17'h10000;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_NONE   = 3'd0;
    localparam t_kind KIND_CORNER = 3'd1;
    localparam t_kind KIND_TRAP   = 3'd2;
    localparam t_kind KIND_COMPL  = 3'd3;
    localparam t_kind KIND_FULL   = 3'd4;

    typedef struct packed {
        logic                      sat;
        logic signed [GRAD_W-1:0]  ofs;
        logic [COLOR_W-1:0]        below;
        logic [COLOR_W-1:0]        above;
    } t_front_side;

    typedef struct packed {
        t_kind               kind;
        logic                sat;
        logic [AREA_W-1:0]   trap;
        logic [COLOR_W-1:0]  below;
        logic [COLOR_W-1:0]  above;
    } t_tri_side;

endpackage

`default_nettype wire

[rtl/core/epcb_front.sv]
// Input stage: magnitudes of the gradient and the slope divider operands.
// Depends on epcb_pkg.
`default_nettype none

module epcb_front
    import epcb_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic signed [GRAD_W-1:0]    i_grad_x,
    input  wire logic signed [GRAD_W-1:0]    i_grad_y,
    input  wire logic signed [GRAD_W-1:0]    i_edge_offset,
    input  wire logic [COLOR_W-1:0]          i_color_below,
    input  wire logic [COLOR_W-1:0]          i_color_above,
    output logic                             o_valid,
    output logic [SLOPE_DIV_W-1:0]           o_rem,
    output logic [SLOPE_Q_W-1:0]             o_low,
    output logic [SLOPE_DIV_W-1:0]           o_div,
    output t_front_side                      o_side
);

    logic [GRAD_W-1:0] n_ax;
    logic [GRAD_W-1:0] n_ay;
    logic              n_sat;

    logic                   r_valid;
    logic [SLOPE_DIV_W-1:0] r_rem;
    logic [SLOPE_Q_W-1:0]   r_low;
    logic [SLOPE_DIV_W-1:0] r_div;
    t_front_side            r_side;

    always_comb begin
        n_ax  = i_grad_x[GRAD_W-1] ? ($unsigned(~i_grad_x) + 16'd1) : $unsigned(i_grad_x);
        n_ay  = i_grad_y[GRAD_W-1] ? ($unsigned(~i_grad_y) + 16'd1) : $unsigned(i_grad_y);
        // quotient overflows 16 bits once |gx| >= 16*|gy|
        n_sat = (n_ay == '0) || ({4'b0000, n_ax} >= {n_ay, 4'b0000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // dividend is |gx| << 12: top 12 bits seed the remainder
    always_ff @(posedge i_clk) begin
        r_rem        <= {4'b0000, n_ax[15:4]};
        r_low        <= {n_ax[3:0], 12'h000};
        r_div        <= n_ay;
        r_side.sat   <= n_sat;
        r_side.ofs   <= i_edge_offset;
        r_side.below <= i_color_below;
        r_side.above <= i_color_above;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_low   = r_low;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

`default_nettype wire

[rtl/core/epcb_divpipe.sv]
// Pipelined restoring divider, BPS quotient bits per register stage, with a
// sideband vector carried alongside. Depends on epcb_pkg.
`default_nettype none

module epcb_divpipe
    import epcb_pkg::*;
#(
    parameter int D_W    = SLOPE_DIV_W,
    parameter int Q_W    = SLOPE_Q_W,
    parameter int BPS    = SLOPE_BPS_DEF,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [D_W-1:0]    i_rem,
    input  wire logic [Q_W-1:0]    i_low,
    input  wire logic [D_W-1:0]    i_div,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int NSTG = (Q_W + BPS - 1) / BPS;

    logic              r_valid [NSTG];
    logic [D_W-1:0]    r_rem   [NSTG];
    logic [D_W-1:0]    r_div   [NSTG];
    logic [Q_W-1:0]    r_low   [NSTG];
    logic [Q_W-1:0]    r_quo   [NSTG];
    logic [SIDE_W-1:0] r_side  [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic              s_valid;
        logic [D_W-1:0]    s_rem;
        logic [D_W-1:0]    s_div;
        logic [Q_W-1:0]    s_low;
        logic [Q_W-1:0]    s_quo;
        logic [SIDE_W-1:0] s_side;
        logic [D_W-1:0]    n_rem;
        logic [Q_W-1:0]    n_low;
        logic [Q_W-1:0]    n_quo;
        logic [D_W:0]      trial;
        logic [D_W:0]      diff;

        if (s == 0) begin : g_head
            assign s_valid = i_valid;
            assign s_rem   = i_rem;
            assign s_div   = i_div;
            assign s_low   = i_low;
            assign s_quo   = '0;
            assign s_side  = i_side;
        end else begin : g_body
            assign s_valid = r_valid[s-1];
            assign s_rem   = r_rem[s-1];
            assign s_div   = r_div[s-1];
            assign s_low   = r_low[s-1];
            assign s_quo   = r_quo[s-1];
            assign s_side  = r_side[s-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            n_rem = s_rem;
            n_low = s_low;
            n_quo = s_quo;
            trial = '0;
            diff  = '0;
            for (int j = 0; j < BPS; j++) begin
                if (s * BPS + j < Q_W) begin
                    trial = {n_rem, n_low[Q_W-1]};
                    diff  = trial - {1'b0, s_div};
                    n_low = n_low << 1;
                    if (trial >= {1'b0, s_div}) begin
                        n_rem = diff[D_W-1:0];
                        n_quo = {n_quo[Q_W-2:0], 1'b1};
                    end else begin
                        n_rem = trial[D_W-1:0];
                        n_quo = {n_quo[Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_div[s]  <= s_div;
            r_low[s]  <= n_low;
            r_quo[s]  <= n_quo;
            r_side[s] <= s_side;
        end
    end

    assign o_valid = r_valid[NSTG-1];
    assign o_quo   = r_quo[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

`default_nettype wire

[rtl/core/epcb_area.sv]
// Edge crossing classification, trapezoid area, and the triangle area
// divider operands (4*s^2 + m over 2*m) over three stages. Depends on epcb_pkg.
`default_nettype none

module epcb_area
    import epcb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [SLOPE_Q_W-1:0]  i_quo,
    input  wire t_front_side           i_side,
    output logic                       o_valid,
    output logic [TRI_DIV_W-1:0]       o_rem,
    output logic [TRI_Q_W-1:0]         o_low,
    output logic [TRI_DIV_W-1:0]       o_div,
    output t_tri_side                  o_side
);

    localparam logic signed [18:0] HALF_Q13     = 19'sd4096;
    localparam logic signed [18:0] NEG_HALF_Q13 = -19'sd4096;
    localparam logic signed [20:0] TRAP_BASE    = 21'sd32768;
    localparam logic signed [20:0] TRAP_TOP     = 21'sd65536;

    // classify
    logic [SLOPE_Q_W-1:0] n_m;
    logic signed [18:0]   n_d2;
    logic signed [18:0]   n_mz;
    logic signed [18:0]   n_y1;
    logic signed [18:0]   n_y2;
    logic signed [18:0]   n_cs;
    logic signed [18:0]   n_ts;
    logic signed [20:0]   n_d16;
    logic signed [20:0]   n_a;
    t_kind                n_kind;
    logic [17:0]          n_s;
    logic [AREA_W-1:0]    n_trap;

    logic                 r1_valid;
    t_kind                r1_kind;
    logic [17:0]          r1_s;
    logic [SLOPE_Q_W-1:0] r1_m;
    logic [AREA_W-1:0]    r1_trap;
    logic [COLOR_W-1:0]   r1_below;
    logic [COLOR_W-1:0]   r1_above;

    logic                 r2_valid;
    t_kind                r2_kind;
    logic [35:0]          r2_sq;
    logic [SLOPE_Q_W-1:0] r2_m;
    logic [AREA_W-1:0]    r2_trap;
    logic [COLOR_W-1:0]   r2_below;
    logic [COLOR_W-1:0]   r2_above;

    logic [37:0]          n_num;
    logic                 n_sat;

    logic                 r3_valid;
    logic [TRI_DIV_W-1:0] r3_rem;
    logic [TRI_Q_W-1:0]   r3_low;
    logic [TRI_DIV_W-1:0] r3_div;
    t_tri_side            r3_side;

    always_comb begin
        n_m   = i_side.sat ? SLOPE_MAX : i_quo;
        n_d2  = {{2{i_side.ofs[15]}}, i_side.ofs, 1'b0};
        n_mz  = $signed({3'b000, n_m});
        n_y1  = n_d2 + n_mz;
        n_y2  = n_d2 - n_mz;
        n_cs  = HALF_Q13 - n_y2;
        n_ts  = n_y1 + HALF_Q13;
        if (n_y2 > HALF_Q13) begin
            n_kind = KIND_NONE;
        end else if (n_y1 > HALF_Q13) begin
            n_kind = KIND_CORNER;
        end else if (n_y2 > NEG_HALF_Q13) begin
            n_kind = KIND_TRAP;
        end else if (n_y1 > NEG_HALF_Q13) begin
            n_kind = KIND_COMPL;
        end else begin
            n_kind = KIND_FULL;
        end
        n_s = (n_kind == KIND_CORNER) ? n_cs[17:0] : n_ts[17:0];

        // trapezoid: 0.5 - d, clamped to the unit range
        n_d16 = {i_side.ofs[15], i_side.ofs, 4'b0000};
        n_a   = TRAP_BASE - n_d16;
        if (n_a < 0) begin
            n_trap = '0;
        end else if (n_a > TRAP_TOP) begin
            n_trap = ONE_Q16;
        end else begin
            n_trap = n_a[16:0];
        end
    end

    always_comb begin
        n_num = {r2_sq, 2'b00} + {22'd0, r2_m};
        n_sat = (r2_m == '0) || (n_num[37:17] >= {4'b0000, r2_m, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind  <= n_kind;
        r1_s     <= n_s;
        r1_m     <= n_m;
        r1_trap  <= n_trap;
        r1_below <= i_side.below;
        r1_above <= i_side.above;

        r2_kind  <= r1_kind;
        r2_sq    <= r1_s * r1_s;
        r2_m     <= r1_m;
        r2_trap  <= r1_trap;
        r2_below <= r1_below;
        r2_above <= r1_above;

        // remainder seed fits 17 bits whenever the quotient does not overflow
        r3_rem        <= n_num[33:17];
        r3_low        <= n_num[16:0];
        r3_div        <= {r2_m, 1'b0};
        r3_side.kind  <= r2_kind;
        r3_side.sat   <= n_sat;
        r3_side.trap  <= r2_trap;
        r3_side.below <= r2_below;
        r3_side.above <= r2_above;
    end

    assign o_valid = r3_valid;
    assign o_rem   = r3_rem;
    assign o_low   = r3_low;
    assign o_div   = r3_div;
    assign o_side  = r3_side;

endmodule

`default_nettype wire

[rtl/core/epcb_blend.sv]
// Final area selection and the rounded two-color blend over three stages.
// Depends on epcb_pkg.
`default_nettype none

module epcb_blend
    import epcb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [TRI_Q_W-1:0]  i_quo,
    input  wire t_tri_side           i_side,
    output logic                     o_valid,
    output logic [COLOR_W-1:0]       o_color
);

    logic [AREA_W-1:0]  n_tri;
    logic [AREA_W-1:0]  n_area;
    logic [AREA_W-1:0]  n_inv;
    logic [33:0]        n_sum;

    logic               r0_valid;
    logic [AREA_W-1:0]  r0_area;
    logic [COLOR_W-1:0] r0_below;
    logic [COLOR_W-1:0] r0_above;

    logic               r1_valid;
    logic [32:0]        r1_pa;
    logic [32:0]        r1_pb;

    logic               r2_valid;
    logic [COLOR_W-1:0] r2_color;

    always_comb begin
        n_tri = (i_side.sat || (i_quo > ONE_Q16)) ? ONE_Q16 : i_quo;
        case (i_side.kind)
            KIND_NONE:   n_area = '0;
            KIND_CORNER: n_area = n_tri;
            KIND_TRAP:   n_area = i_side.trap;
            KIND_COMPL:  n_area = ONE_Q16 - n_tri;
            KIND_FULL:   n_area = ONE_Q16;
            default:     n_area = ONE_Q16;
        endcase
    end

    always_comb begin
        n_inv = ONE_Q16 - r0_area;
        n_sum = {1'b0, r1_pa} + {1'b0, r1_pb} + 34'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_area  <= n_area;
        r0_below <= i_side.below;
        r0_above <= i_side.above;
        r1_pa    <= r0_area * r0_below;
        r1_pb    <= n_inv * r0_above;
        r2_color <= n_sum[31:16];
    end

    assign o_valid = r2_valid;
    assign o_color = r2_color;

endmodule

`default_nettype wire

[rtl/core/edge_pixel_coverage_blend.sv]
// Top level of the edge pixel coverage blend pipeline.
// Depends on epcb_pkg, epcb_front, epcb_divpipe, epcb_area, epcb_blend.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+----------------------
//  input    | i_grad_x i_grad_y i_edge_offset              | start, busy
//           | i_color_below i_color_above                  |
//  result   | o_pixel_color                                | o_strobe (one cycle)
//
// One transaction per cycle; busy stays low. Each one passes the front register,
// the slope divider pipeline, the area stages, the triangle area divider pipeline
// and the blend stages; both dividers are restoring divider pipelines.
// Synchronous active-low reset clears only the valid bits.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none

module edge_pixel_coverage_blend
    import epcb_pkg::*;
#(
    parameter int SLOPE_BPS = SLOPE_BPS_DEF,
    parameter int TRI_BPS   = TRI_BPS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [GRAD_W-1:0]  i_grad_x,
    input  wire logic signed [GRAD_W-1:0]  i_grad_y,
    input  wire logic signed [GRAD_W-1:0]  i_edge_offset,
    input  wire logic [COLOR_W-1:0]        i_color_below,
    input  wire logic [COLOR_W-1:0]        i_color_above,
    output logic                           o_strobe,
    output logic [COLOR_W-1:0]             o_pixel_color
);

    localparam int FRONT_SIDE_W = $bits(t_front_side);
    localparam int TRI_SIDE_W   = $bits(t_tri_side);

    logic                    fr_valid;
    logic [SLOPE_DIV_W-1:0]  fr_rem;
    logic [SLOPE_Q_W-1:0]    fr_low;
    logic [SLOPE_DIV_W-1:0]  fr_div;
    t_front_side             fr_side;

    logic                    sd_valid;
    logic [SLOPE_Q_W-1:0]    sd_quo;
    logic [FRONT_SIDE_W-1:0] sd_side_vec;
    t_front_side             sd_side;

    logic                    ar_valid;
    logic [TRI_DIV_W-1:0]    ar_rem;
    logic [TRI_Q_W-1:0]      ar_low;
    logic [TRI_DIV_W-1:0]    ar_div;
    t_tri_side               ar_side;

    logic                    td_valid;
    logic [TRI_Q_W-1:0]      td_quo;
    logic [TRI_SIDE_W-1:0]   td_side_vec;
    t_tri_side               td_side;

    assign busy = 1'b0;

    epcb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_edge_offset (i_edge_offset),
        .i_color_below (i_color_below),
        .i_color_above (i_color_above),
        .o_valid       (fr_valid),
        .o_rem         (fr_rem),
        .o_low         (fr_low),
        .o_div         (fr_div),
        .o_side        (fr_side)
    );

    epcb_divpipe #(
        .D_W    (SLOPE_DIV_W),
        .Q_W    (SLOPE_Q_W),
        .BPS    (SLOPE_BPS),
        .SIDE_W (FRONT_SIDE_W)
    ) u_slope_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rem   (fr_rem),
        .i_low   (fr_low),
        .i_div   (fr_div),
        .i_side  (fr_side),
        .o_valid (sd_valid),
        .o_quo   (sd_quo),
        .o_side  (sd_side_vec)
    );

    assign sd_side = t_front_side'(sd_side_vec);

    epcb_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sd_valid),
        .i_quo   (sd_quo),
        .i_side  (sd_side),
        .o_valid (ar_valid),
        .o_rem   (ar_rem),
        .o_low   (ar_low),
        .o_div   (ar_div),
        .o_side  (ar_side)
    );

    epcb_divpipe #(
        .D_W    (TRI_DIV_W),
        .Q_W    (TRI_Q_W),
        .BPS    (TRI_BPS),
        .SIDE_W (TRI_SIDE_W)
    ) u_tri_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ar_valid),
        .i_rem   (ar_rem),
        .i_low   (ar_low),
        .i_div   (ar_div),
        .i_side  (ar_side),
        .o_valid (td_valid),
        .o_quo   (td_quo),
        .o_side  (td_side_vec)
    );

    assign td_side = t_tri_side'(td_side_vec);

    epcb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (td_valid),
        .i_quo   (td_quo),
        .i_side  (td_side),
        .o_valid (o_strobe),
        .o_color (o_pixel_color)
    );

endmodule

`default_nettype wire

[rtl/core/epcb_checker.sv]
// Port-level checker for edge_pixel_coverage_blend, attached by bind.
// Depends on epcb_pkg and edge_pixel_coverage_blend_assert.svh.
`default_nettype none

`include "edge_pixel_coverage_blend_assert.svh"

module epcb_checker
    import epcb_pkg::*;
#(
    parameter int SLOPE_BPS = SLOPE_BPS_DEF,
    parameter int TRI_BPS   = TRI_BPS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [COLOR_W-1:0] i_color_below,
    input wire logic [COLOR_W-1:0] i_color_above,
    input wire logic               o_strobe,
    input wire logic [COLOR_W-1:0] o_pixel_color
);

    localparam int LAT = 1 + (SLOPE_Q_W + SLOPE_BPS - 1) / SLOPE_BPS + 3
                       + (TRI_Q_W + TRI_BPS - 1) / TRI_BPS + 3;

    `EPCB_ASSERT_NEVER(a_never_busy, busy, "busy raised on a fully pipelined block")
    `EPCB_ASSERT_DELAY(a_result_follows, start && !busy, LAT, o_strobe, "accepted transaction produced no result")
    `EPCB_ASSERT_DELAY(a_no_spurious, !(start && !busy), LAT, !o_strobe, "result strobe without a transaction")
    `EPCB_ASSERT_IMPLY(a_equal_colors, o_strobe && ($past(i_color_below, LAT) == $past(i_color_above, LAT)), o_pixel_color == $past(i_color_below, LAT), "blend of equal colors changed the color")

endmodule

bind edge_pixel_coverage_blend epcb_checker #(
    .SLOPE_BPS (SLOPE_BPS),
    .TRI_BPS   (TRI_BPS)
) u_epcb_checker (.*);

`default_nettype wire
